// ----- sv/ncp_pkg.sv -----
// Shared types, codes and saturating arithmetic for the nested call time profiler.
package ncp_pkg;

    localparam int FUNCTION_COUNT_DEFAULT = 64;
    localparam int STACK_DEPTH_DEFAULT    = 16;

    localparam int OP_W     = 3;
    localparam int ID_W     = 6;
    localparam int TIME_W   = 63;
    localparam int COUNT_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_ENTER = 3'd2,
        OP_LEAVE = 3'd3,
        OP_READ  = 3'd4
    } ncp_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE     = 2'd0,
        STS_IGNORED  = 2'd1,
        STS_NO_ENTER = 2'd2,
        STS_FULL     = 2'd3
    } ncp_status_t;

    typedef struct packed {
        logic [COUNT_W-1:0] calls;
        logic [TIME_W-1:0]  incl;
        logic [TIME_W-1:0]  below;
    } ncp_rec_t;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] child;
    } ncp_frame_t;

    typedef struct packed {
        logic issue;
        logic push;
        logic pop;
        logic clear;
    } ncp_stk_cmd_t;

    typedef struct packed {
        logic issue;
        logic write;
        logic clear;
    } ncp_tbl_cmd_t;

    function automatic logic [TIME_W-1:0] sat_add63(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc32(input logic [COUNT_W-1:0] a);
        return (a == COUNT_MAX) ? COUNT_MAX : a + COUNT_W'(1);
    endfunction

endpackage

// ----- sv/ncp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module ncp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/ncp_stack.sv -----
// Call stack: top frame in registers, frames beneath it in a RAM.
module ncp_stack #(
    parameter int STACK_DEPTH = ncp_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ncp_pkg::ncp_stk_cmd_t              cmd,
    input  logic [ncp_pkg::TIME_W-1:0]         ts,
    input  logic [ncp_pkg::TIME_W-1:0]         dur,
    output logic [$clog2(STACK_DEPTH+1)-1:0]   sp,
    output logic [ncp_pkg::TIME_W-1:0]         stamp_top,
    output logic [ncp_pkg::TIME_W-1:0]         child_top
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [DW-1:0]                 sp_reg, sp_next;
    logic [ncp_pkg::TIME_W-1:0]    stamp_top_reg, stamp_top_next;
    logic [ncp_pkg::TIME_W-1:0]    child_top_reg, child_top_next;
    ncp_pkg::ncp_frame_t           wr_frame, rd_frame;
    logic [$bits(ncp_pkg::ncp_frame_t)-1:0] rd_bits;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr, rd_addr;

    assign wr_en    = cmd.push && (sp_reg != '0);
    assign wr_addr  = AW'(sp_reg - DW'(1));
    assign rd_addr  = AW'(sp_reg - DW'(2));
    assign wr_frame = '{stamp: stamp_top_reg, child: child_top_reg};
    assign rd_frame = ncp_pkg::ncp_frame_t'(rd_bits);

    ncp_ram #(
        .WIDTH ($bits(ncp_pkg::ncp_frame_t)),
        .DEPTH (STACK_DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_frame),
        .rd_en   (cmd.issue),
        .rd_addr (rd_addr),
        .rd_data (rd_bits)
    );

    always_comb
    begin
        sp_next        = sp_reg;
        stamp_top_next = stamp_top_reg;
        child_top_next = child_top_reg;
        priority if (cmd.clear)
        begin
            sp_next = '0;
        end
        else if (cmd.push)
        begin
            sp_next        = sp_reg + DW'(1);
            stamp_top_next = ts;
            child_top_next = '0;
        end
        else if (cmd.pop)
        begin
            // Promote the parent frame and credit it with the callee's duration.
            sp_next        = sp_reg - DW'(1);
            stamp_top_next = rd_frame.stamp;
            child_top_next = ncp_pkg::sat_add63(rd_frame.child, dur);
        end
        else
        begin
            sp_next = sp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stamp_top_reg <= stamp_top_next;
        child_top_reg <= child_top_next;
    end

    assign sp        = sp_reg;
    assign stamp_top = stamp_top_reg;
    assign child_top = child_top_reg;

endmodule

// ----- sv/ncp_table.sv -----
// Per-function record table in RAM with a zeroing sweep after reset and on start.
module ncp_table #(
    parameter int FUNCTION_COUNT = ncp_pkg::FUNCTION_COUNT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ncp_pkg::ncp_tbl_cmd_t             cmd,
    input  logic [$clog2(FUNCTION_COUNT)-1:0] rd_idx,
    input  logic [$clog2(FUNCTION_COUNT)-1:0] wr_idx,
    input  ncp_pkg::ncp_rec_t                 wr_rec,
    output ncp_pkg::ncp_rec_t                 rd_rec,
    output logic                              busy
);

    localparam int AW = $clog2(FUNCTION_COUNT);

    logic          busy_reg, busy_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [$bits(ncp_pkg::ncp_rec_t)-1:0] ram_wr_data, ram_rd_data;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        priority if (cmd.clear)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + AW'(1);
            if (cnt_reg == AW'(FUNCTION_COUNT - 1))
            begin
                busy_next = 1'b0;
            end
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign ram_wr_en   = busy_reg || cmd.write;
    assign ram_wr_addr = busy_reg ? cnt_reg : wr_idx;
    assign ram_wr_data = busy_reg ? '0 : wr_rec;

    ncp_ram #(
        .WIDTH ($bits(ncp_pkg::ncp_rec_t)),
        .DEPTH (FUNCTION_COUNT)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.issue),
        .rd_addr (rd_idx),
        .rd_data (ram_rd_data)
    );

    assign rd_rec = ncp_pkg::ncp_rec_t'(ram_rd_data);
    assign busy   = busy_reg;

endmodule

// ----- sv/nested_call_time_profiler_core.sv -----
// Top level of the nested call time profiler: event control, session counters, response register.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------------------
//  request   | req_valid / req_ready | opcode, function_id, timestamp
//  response  | res_valid / res_ready | status, record_id, call_count, inclusive_time,
//            |                       | child_time, top_level_time, error_count,
//            |                       | is_active, nesting_depth, session_time
//
//  Each request has a read step, reading the record RAM and the frame RAM, and an
//  update step that updates and writes back; the RAM read data is registered.
//  A request is taken while the previous response still waits; its write-back waits
//  until that response is taken.
//  After reset and after every start, a sweep zeroes all FUNCTION_COUNT records of
//  the record RAM, with req_ready low while it runs.
module nested_call_time_profiler_core #(
    parameter int FUNCTION_COUNT = ncp_pkg::FUNCTION_COUNT_DEFAULT,
    parameter int STACK_DEPTH    = ncp_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [ncp_pkg::OP_W-1:0]           opcode,
    input  logic [ncp_pkg::ID_W-1:0]           function_id,
    input  logic [ncp_pkg::TIME_W-1:0]         timestamp,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic [ncp_pkg::STATUS_W-1:0]       status,
    output logic [ncp_pkg::ID_W-1:0]           record_id,
    output logic [ncp_pkg::COUNT_W-1:0]        call_count,
    output logic [ncp_pkg::TIME_W-1:0]         inclusive_time,
    output logic [ncp_pkg::TIME_W-1:0]         child_time,
    output logic [ncp_pkg::TIME_W-1:0]         top_level_time,
    output logic [ncp_pkg::COUNT_W-1:0]        error_count,
    output logic                               is_active,
    output logic [$clog2(STACK_DEPTH+1)-1:0]   nesting_depth,
    output logic [ncp_pkg::TIME_W-1:0]         session_time
);

    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int TAW = $clog2(FUNCTION_COUNT);
    localparam int TW  = ncp_pkg::TIME_W;
    localparam int CW  = ncp_pkg::COUNT_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } ncp_state_t;

    function automatic logic [ncp_pkg::ID_W-1:0] reduce_id(input logic [ncp_pkg::ID_W-1:0] id);
        logic [23:0] r;
        logic [23:0] lim;
        r = 24'(id);
        for (int k = ncp_pkg::ID_W - 1; k >= 0; k--)
        begin
            lim = 24'(FUNCTION_COUNT) << k;
            if (r >= lim)
            begin
                r = r - lim;
            end
        end
        return r[ncp_pkg::ID_W-1:0];
    endfunction

    ncp_state_t                  state_reg, state_next;
    logic [ncp_pkg::OP_W-1:0]    op_reg;
    logic [ncp_pkg::ID_W-1:0]    rid_reg, rid_in;
    logic [TW-1:0]               ts_reg, dur_reg, dur_in;
    logic                        neg_reg, neg_in;
    logic [TW:0]                 diff_in;

    logic                        running_reg, running_next;
    logic [TW-1:0]               top_reg, top_next;
    logic [CW-1:0]               err_reg, err_next;
    logic [TW-1:0]               sess_start_reg, sess_start_next;
    logic [TW-1:0]               sess_stop_reg, sess_stop_next;
    logic [TW-1:0]               sess_time_reg, sess_time_next;

    logic                        res_valid_reg, res_valid_next;
    logic [ncp_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [ncp_pkg::ID_W-1:0]    record_id_reg;
    ncp_pkg::ncp_rec_t           rec_out_reg, rec_out_next;

    logic                        accept, commit;
    logic                        is_start, is_stop, is_enter, is_leave;
    logic                        push_ok, pop_ok;

    ncp_pkg::ncp_stk_cmd_t       stk_cmd;
    ncp_pkg::ncp_tbl_cmd_t       tbl_cmd;
    logic [DW-1:0]               stk_sp;
    logic [TW-1:0]               stk_stamp, stk_child;
    ncp_pkg::ncp_rec_t           tbl_rd, tbl_new;
    logic                        tbl_busy;

    assign req_ready = (state_reg == ST_IDLE) && !tbl_busy;
    assign accept    = req_valid && req_ready;
    assign commit    = (state_reg == ST_EXEC) && (!res_valid_reg || res_ready);

    assign rid_in  = reduce_id(function_id);
    assign diff_in = {1'b0, timestamp} - {1'b0, stk_stamp};
    assign neg_in  = diff_in[TW];
    assign dur_in  = neg_in ? '0 : diff_in[TW-1:0];

    always_comb
    begin
        is_start = 1'b0;
        is_stop  = 1'b0;
        is_enter = 1'b0;
        is_leave = 1'b0;
        unique case (op_reg)
            ncp_pkg::OP_START: is_start = 1'b1;
            ncp_pkg::OP_STOP:  is_stop  = 1'b1;
            ncp_pkg::OP_ENTER: is_enter = 1'b1;
            ncp_pkg::OP_LEAVE: is_leave = 1'b1;
            default:           is_start = 1'b0;
        endcase
    end

    assign push_ok = is_enter && running_reg && (stk_sp != DW'(STACK_DEPTH));
    assign pop_ok  = is_leave && running_reg && (stk_sp != '0);

    always_comb
    begin
        priority if ((is_enter || is_leave) && !running_reg)
        begin
            status_next = ncp_pkg::STS_IGNORED;
        end
        else if (is_enter && !push_ok)
        begin
            status_next = ncp_pkg::STS_FULL;
        end
        else if (is_leave && !pop_ok)
        begin
            status_next = ncp_pkg::STS_NO_ENTER;
        end
        else
        begin
            status_next = ncp_pkg::STS_DONE;
        end
    end

    assign stk_cmd = '{issue: accept, push: commit && push_ok, pop: commit && pop_ok,
                       clear: commit && is_start};
    assign tbl_cmd = '{issue: accept, write: commit && pop_ok, clear: commit && is_start};

    assign tbl_new.calls = ncp_pkg::sat_inc32(tbl_rd.calls);
    assign tbl_new.incl  = ncp_pkg::sat_add63(tbl_rd.incl, dur_reg);
    assign tbl_new.below = ncp_pkg::sat_add63(tbl_rd.below, stk_child);

    ncp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ncp_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (stk_cmd),
        .ts        (ts_reg),
        .dur       (dur_reg),
        .sp        (stk_sp),
        .stamp_top (stk_stamp),
        .child_top (stk_child)
    );

    ncp_table #(
        .FUNCTION_COUNT (FUNCTION_COUNT)
    ) u_ncp_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (tbl_cmd),
        .rd_idx (TAW'(rid_in)),
        .wr_idx (TAW'(rid_reg)),
        .wr_rec (tbl_new),
        .rd_rec (tbl_rd),
        .busy   (tbl_busy)
    );

    always_comb
    begin
        running_next    = running_reg;
        top_next        = top_reg;
        err_next        = err_reg;
        sess_start_next = sess_start_reg;
        sess_stop_next  = sess_stop_reg;
        rec_out_next    = tbl_rd;
        if (is_start)
        begin
            running_next    = 1'b1;
            top_next        = '0;
            err_next        = '0;
            sess_start_next = ts_reg;
            rec_out_next    = '0;
        end
        if (is_stop)
        begin
            running_next   = 1'b0;
            sess_stop_next = ts_reg;
        end
        if (pop_ok)
        begin
            rec_out_next = tbl_new;
            if (neg_reg)
            begin
                err_next = ncp_pkg::sat_inc32(err_reg);
            end
            if (stk_sp == DW'(1))
            begin
                top_next = ncp_pkg::sat_add63(top_reg, dur_reg);
            end
        end
        sess_time_next = (sess_stop_next >= sess_start_next) ?
                         (sess_stop_next - sess_start_next) : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            res_valid_reg  <= 1'b0;
            running_reg    <= 1'b0;
            top_reg        <= '0;
            err_reg        <= '0;
            sess_start_reg <= '0;
            sess_stop_reg  <= '0;
            sess_time_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (commit)
            begin
                running_reg    <= running_next;
                top_reg        <= top_next;
                err_reg        <= err_next;
                sess_start_reg <= sess_start_next;
                sess_stop_reg  <= sess_stop_next;
                sess_time_reg  <= sess_time_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            rid_reg <= rid_in;
            ts_reg  <= timestamp;
            dur_reg <= dur_in;
            neg_reg <= neg_in;
        end
        if (commit)
        begin
            status_reg    <= status_next;
            record_id_reg <= rid_reg;
            rec_out_reg   <= rec_out_next;
        end
    end

    assign res_valid      = res_valid_reg;
    assign status         = status_reg;
    assign record_id      = record_id_reg;
    assign call_count     = rec_out_reg.calls;
    assign inclusive_time = rec_out_reg.incl;
    assign child_time     = rec_out_reg.below;
    assign top_level_time = top_reg;
    assign error_count    = err_reg;
    assign is_active      = running_reg;
    assign nesting_depth  = stk_sp;
    assign session_time   = sess_time_reg;

endmodule

// ----- sv/ncp_checker.sv -----
// Port-level checks for the nested call time profiler, bound to the top level.
module ncp_checker #(
    parameter int STACK_DEPTH = ncp_pkg::STACK_DEPTH_DEFAULT
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             req_valid,
    input logic                             req_ready,
    input logic                             res_valid,
    input logic                             res_ready,
    input logic [ncp_pkg::STATUS_W-1:0]     status,
    input logic                             is_active,
    input logic [$clog2(STACK_DEPTH+1)-1:0] nesting_depth
);

    localparam int DW = $clog2(STACK_DEPTH + 1);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous request still in work");

    a_ignored_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ncp_pkg::STS_IGNORED) |-> !is_active)
        else $error("ignored status while session active");

    a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ncp_pkg::STS_FULL) |-> (nesting_depth == DW'(STACK_DEPTH)))
        else $error("stack full status with stack not full");

    a_empty_leave: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (status == ncp_pkg::STS_NO_ENTER) |-> (nesting_depth == '0) && is_active)
        else $error("leave-without-enter status with nonempty stack or no session");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(status))
        else $error("response dropped or changed while stalled");

endmodule

bind nested_call_time_profiler_core ncp_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_ncp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .status        (status),
    .is_active     (is_active),
    .nesting_depth (nesting_depth)
);
